// ===== sv/ldr_window_tone_filter_core_defines.svh =====
// Assertion macros shared by the checker of the window tone filter.
// No dependencies; every user includes this header by its bare name.
`ifndef LDR_WINDOW_TONE_FILTER_CORE_DEFINES_SVH
`define LDR_WINDOW_TONE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define LDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define LDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ldr_pkg.sv =====
// Types and constants of the window tone filter.
// No dependencies; used by every module of the block.
package ldr_pkg;

    // config register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam int          CFG_DATA_W = 13;
    localparam int          ROW_W      = 12;
    localparam int          MAX_HEIGHT = 4096;
    localparam int          MIN_DIM    = 5;

    // 5*5*255*3*255
    localparam int          TONE_DIV   = 4876875;
    // 256 * TONE_DIV, keeps the signed product non-negative
    localparam int          TONE_BIAS  = 1248480000;
    // floor(2^32 / TONE_DIV), never overestimates the quotient
    localparam int          TONE_RECIP = 880;

    localparam int          QDEPTH     = 8;
    localparam int          QPTR_W     = 3;
    localparam int          QCNT_W     = 4;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic [7:0] in_opacity;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_opacity;
        logic       frame_end;
    } out_word_t;

    // what the front hands to the back for one interior pixel
    typedef struct packed {
        logic [14:0] win_sum;
        in_word_t    pix;
        logic        frame_end;
    } work_t;

    function automatic logic [9:0] chan_sum(input in_word_t p);
        chan_sum = 10'(p.in_blue) + 10'(p.in_green) + 10'(p.in_red);
    endfunction

endpackage

// ===== sv/ldr_front.sv =====
// Front end: raster counters, four line stores and the 5x5 window column sums.
// Uses ldr_pkg; pushes one work word per interior pixel into the queue.
module ldr_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      acc,
    input  ldr_pkg::in_word_t         pix,
    input  logic [10:0]               image_width,
    input  logic [12:0]               image_height,
    output logic                      push,
    output ldr_pkg::work_t            push_word,
    output logic [1:0]                busy_cnt
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [CW-1:0]               col_reg, col_next;
    logic [ldr_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [CW:0]                 w_eff;
    logic [12:0]                 h_eff;
    logic                        inw, emit, fend;

    // stage 1: line store read in flight
    logic                        s1_v_reg, s1_e_reg, s1_f_reg;
    ldr_pkg::in_word_t           s1_px_reg;
    logic [1:0]                  s1_row_reg;
    logic [31:0]                 rd [4];

    // stage 2: new column ready
    logic                        s2_v_reg, s2_e_reg, s2_f_reg;
    logic [11:0]                 s2_cs_reg;
    ldr_pkg::in_word_t           s2_cen_reg;

    // window state: column sums of window cols 1..4, centre row of cols 3..4
    logic [11:0]                 cs_reg [4];
    ldr_pkg::in_word_t           c3_reg, c4_reg;

    logic [11:0]                 col_sum;
    ldr_pkg::in_word_t           wcol [5];

    always_comb
    begin
        if (32'(image_width) > MAX_WIDTH)
            w_eff = (CW+1)'(MAX_WIDTH);
        else if (32'(image_width) < ldr_pkg::MIN_DIM)
            w_eff = (CW+1)'(ldr_pkg::MIN_DIM);
        else
            w_eff = (CW+1)'(image_width);
        if (32'(image_height) > ldr_pkg::MAX_HEIGHT)
            h_eff = 13'(ldr_pkg::MAX_HEIGHT);
        else if (32'(image_height) < ldr_pkg::MIN_DIM)
            h_eff = 13'(ldr_pkg::MIN_DIM);
        else
            h_eff = image_height;
    end

    always_comb
    begin
        inw  = ((CW+1)'(col_reg) < w_eff) && (13'(row_reg) < h_eff);
        emit = inw && (32'(col_reg) >= 4) && (32'(row_reg) >= 4);
        fend = emit && (13'(row_reg) == h_eff - 13'd1)
                    && ((CW+1)'(col_reg) == w_eff - (CW+1)'(1));
        col_next = col_reg;
        row_next = row_reg;
        if ((CW+1)'(col_reg) + (CW+1)'(1) >= w_eff)
        begin
            col_next = '0;
            if (13'(row_reg) + 13'd1 >= h_eff)
                row_next = '0;
            else
                row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // one bank per row slot; read-before-write on the shared address
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [31:0] mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (acc && inw)
            begin
                rd[g] <= mem[col_reg];
                if (row_reg[1:0] == 2'(g))
                    mem[col_reg] <= pix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s1_e_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s2_e_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= acc && inw;
            s1_e_reg <= acc && emit;
            s2_v_reg <= s1_v_reg;
            s2_e_reg <= s1_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_f_reg   <= fend;
        s1_px_reg  <= pix;
        s1_row_reg <= row_reg[1:0];
        s2_f_reg   <= s1_f_reg;
        s2_cs_reg  <= col_sum;
        s2_cen_reg <= wcol[2];
    end

    // slot (row + r) mod 4 holds row - 4 + r
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            wcol[r] = rd[2'(s1_row_reg + 2'(r))];
        wcol[4] = s1_px_reg;
        col_sum = '0;
        for (int r = 0; r < 5; r++)
            col_sum = col_sum + 12'(ldr_pkg::chan_sum(wcol[r]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                cs_reg[i] <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            cs_reg[0] <= cs_reg[1];
            cs_reg[1] <= cs_reg[2];
            cs_reg[2] <= cs_reg[3];
            cs_reg[3] <= s2_cs_reg;
            c3_reg    <= c4_reg;
            c4_reg    <= s2_cen_reg;
        end
    end

    always_comb
    begin
        push                = s2_e_reg;
        push_word.win_sum   = 15'(cs_reg[0]) + 15'(cs_reg[1]) + 15'(cs_reg[2])
                            + 15'(cs_reg[3]) + 15'(s2_cs_reg);
        push_word.pix       = c3_reg;
        push_word.frame_end = s2_f_reg;
        busy_cnt            = 2'(s1_e_reg) + 2'(s2_e_reg);
    end

endmodule

// ===== sv/ldr_queue.sv =====
// Short FIFO of work words between the front and the back end.
// Uses ldr_pkg for the word type and depth.
module ldr_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  ldr_pkg::work_t              push_word,
    input  logic                        pop,
    output logic                        q_valid,
    output ldr_pkg::work_t              q_word,
    output logic [ldr_pkg::QCNT_W-1:0]  q_count
);
    ldr_pkg::work_t                 slot [ldr_pkg::QDEPTH];
    logic [ldr_pkg::QPTR_W-1:0]     wp_reg, rp_reg;
    logic [ldr_pkg::QCNT_W-1:0]     cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wp_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ldr_pkg::QCNT_W'(push) - ldr_pkg::QCNT_W'(pop);
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_word  = slot[rp_reg];
    assign q_count = cnt_reg;

endmodule

// ===== sv/ldr_back.sv =====
// Back end: gain * window sum * channel, floor divide by the constant, add the channel, clamp.
// Uses ldr_pkg; pops the queue and drives the output register.
module ldr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [8:0]    gain,
    input  logic                 q_valid,
    input  ldr_pkg::work_t       q_word,
    output logic                 pop,
    output logic                 out_valid,
    output ldr_pkg::out_word_t   out_word,
    input  logic                 out_stall
);
    logic                 adv;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, ov_reg;
    logic [7:0]           ch1_reg [3], ch2_reg [3], ch3_reg [3], ch4_reg [3];
    logic [7:0]           op1_reg, op2_reg, op3_reg, op4_reg;
    logic                 fe1_reg, fe2_reg, fe3_reg, fe4_reg;
    logic signed [24:0]   p_reg;
    logic [31:0]          x2_reg [3], x3_reg [3];
    logic [9:0]           q3_reg [3], q4_reg [3];
    logic [23:0]          r4_reg [3];
    ldr_pkg::out_word_t   ow_reg;

    logic signed [33:0]   x_next [3];
    logic [28:0]          m_next [3];
    logic [32:0]          qd_next [3];
    logic [7:0]           res [3];
    logic signed [11:0]   v [3];
    logic [1:0]           inc [3];

    assign adv = !ov_reg || !out_stall;
    assign pop = q_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            ov_reg <= v4_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            x_next[i]  = 34'(p_reg * $signed({1'b0, ch1_reg[i]}))
                       + 34'(ldr_pkg::TONE_BIAS);
            m_next[i]  = 29'(x2_reg[i][31:13]) * 29'(ldr_pkg::TONE_RECIP);
            qd_next[i] = 33'(x3_reg[i]) - 33'(q3_reg[i]) * 33'(ldr_pkg::TONE_DIV);
            if (32'(r4_reg[i]) >= 2 * ldr_pkg::TONE_DIV)
                inc[i] = 2'd2;
            else if (32'(r4_reg[i]) >= ldr_pkg::TONE_DIV)
                inc[i] = 2'd1;
            else
                inc[i] = 2'd0;
            v[i] = $signed({4'b0, ch4_reg[i]}) + $signed({2'b0, q4_reg[i]})
                 + $signed({10'b0, inc[i]}) - 12'sd256;
            if (v[i] < 12'sd0)
                res[i] = 8'd0;
            else if (v[i] > 12'sd255)
                res[i] = 8'd255;
            else
                res[i] = v[i][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg      <= 25'(gain * $signed({1'b0, q_word.win_sum}));
            ch1_reg[0] <= q_word.pix.in_blue;
            ch1_reg[1] <= q_word.pix.in_green;
            ch1_reg[2] <= q_word.pix.in_red;
            op1_reg    <= q_word.pix.in_opacity;
            fe1_reg    <= q_word.frame_end;
            op2_reg    <= op1_reg;
            fe2_reg    <= fe1_reg;
            op3_reg    <= op2_reg;
            fe3_reg    <= fe2_reg;
            op4_reg    <= op3_reg;
            fe4_reg    <= fe3_reg;
            for (int i = 0; i < 3; i++)
            begin
                ch2_reg[i] <= ch1_reg[i];
                ch3_reg[i] <= ch2_reg[i];
                ch4_reg[i] <= ch3_reg[i];
                x2_reg[i]  <= x_next[i][31:0];
                x3_reg[i]  <= x2_reg[i];
                q3_reg[i]  <= m_next[i][28:19];
                q4_reg[i]  <= q3_reg[i];
                r4_reg[i]  <= qd_next[i][23:0];
            end
            ow_reg.out_blue    <= res[0];
            ow_reg.out_green   <= res[1];
            ow_reg.out_red     <= res[2];
            ow_reg.out_opacity <= op4_reg;
            ow_reg.frame_end   <= fe4_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

endmodule

// ===== sv/ldr_window_tone_filter_core.sv =====
// Window tone filter: takes BGRA pixels in raster order, one word per accepted
// cycle, and for every pixel at least two from each edge emits its colour bytes
// adjusted by gain * (sum of r+g+b over the 5x5 window) * channel / 4876875
// (floored, clamped to 0..255) with alpha passed through; border pixels give no
// word. Sustained rate is one pixel per clock on both sides while out_stall is
// low. A pixel passes through the front end (line store read, column sum, window
// update) and the back end (gain product, channel product, quotient estimate,
// remainder, correction and clamp) before its word shows at the output. in_stall
// rises only when the 8-word queue together with the words still in the front
// end would be full, so a stalled output backs up into the input after at most
// thirteen words (five in the back end, eight in the queue).
// Line stores are not cleared after reset: a new frame writes each row before it
// reads it. Configure width, height and gain only while the block is idle.
// Depends on ldr_pkg, ldr_front, ldr_queue and ldr_back.
module ldr_window_tone_filter_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [ldr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ldr_pkg::in_word_t                  in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ldr_pkg::out_word_t                 out_word
);
    logic [10:0]                       width_reg;
    logic [12:0]                       height_reg;
    logic signed [8:0]                 gain_reg;

    logic                              acc;
    logic                              push, pop, q_valid;
    ldr_pkg::work_t                    push_word, q_word;
    logic [ldr_pkg::QCNT_W-1:0]        q_count;
    logic [1:0]                        busy_cnt;

    // config registers; an unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd5;
            height_reg <= 13'd5;
            gain_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ldr_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                ldr_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                ldr_pkg::REG_GAIN:   gain_reg   <= $signed(cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    // credit check: every word still in the front end owns a queue slot
    assign in_stall = (q_count + ldr_pkg::QCNT_W'(busy_cnt)) >=
                      ldr_pkg::QCNT_W'(ldr_pkg::QDEPTH);
    assign acc      = in_valid && !in_stall;

    ldr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .pix          (in_word),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (push),
        .push_word    (push_word),
        .busy_cnt     (busy_cnt)
    );

    ldr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_count   (q_count)
    );

    ldr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .pop       (pop),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_stall (out_stall)
    );

endmodule

// ===== sv/ldr_core_checker.sv =====
// Port-level checks of the window tone filter core, bound to the top level.
// Depends on ldr_pkg and ldr_window_tone_filter_core_defines.svh.
`include "ldr_window_tone_filter_core_defines.svh"

module ldr_core_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ldr_pkg::out_word_t  out_word
);

    // stall only rises after a word came in
    `LDR_ASSERT_IMP(a_stall_rise, $rose(in_stall), $past(in_valid && !in_stall), "stall rose without input")

    // out of reset both sides are empty
    `LDR_ASSERT_IMP(a_reset_clear, $past(!rst_n), !out_valid && !in_stall, "not clear after reset")

    // a stalled result word is held
    `LDR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "output word dropped")

endmodule

bind ldr_window_tone_filter_core ldr_core_checker u_chk (.*);

// ===== dv/tb_ldr_window_tone_filter_core.sv =====
// Self-checking bench for ldr_window_tone_filter_core: raster frames of BGRA words
// against a cycle-free predictor of the 5x5 window tone adjustment.
// Depends on ldr_pkg and the RTL of the block.
module tb_ldr_window_tone_filter_core;

    localparam int MAXW      = 1024;
    localparam int PIPE_WAIT = 24;    // front end + back end + queue slack
    localparam int DOG_LIMIT = 5000;
    localparam int HOLD_LEN  = 300;

    // Predictor and store of expected output words.
    class tone_scoreboard;
        ldr_pkg::in_word_t   line_mem [4*MAXW];
        ldr_pkg::in_word_t   win [5][5];
        int unsigned         col, row;
        int unsigned         reg_w, reg_h;
        int                  reg_gain;
        ldr_pkg::out_word_t  expected_q [$];

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            col = 0;
            row = 0;
            reg_w = 5;
            reg_h = 5;
            reg_gain = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [ldr_pkg::CFG_DATA_W-1:0] val);
            if (idx == ldr_pkg::REG_WIDTH)
                reg_w = val[10:0];
            else if (idx == ldr_pkg::REG_HEIGHT)
                reg_h = val[12:0];
            else if (idx == ldr_pkg::REG_GAIN)
                reg_gain = $signed(val[8:0]);
        endfunction

        function logic [7:0] tone(logic [7:0] c, longint s);
            longint prod, q, v;
            prod = longint'(reg_gain) * s * longint'(c);
            if (prod >= 0)
                q = prod / ldr_pkg::TONE_DIV;
            else
                q = -((-prod + ldr_pkg::TONE_DIV - 1) / ldr_pkg::TONE_DIV);
            v = longint'(c) + q;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return v[7:0];
        endfunction

        function void note_pixel(ldr_pkg::in_word_t px);
            int unsigned         w, h, slot;
            longint              s;
            ldr_pkg::in_word_t   ctr;
            ldr_pkg::out_word_t  e;
            w = (reg_w < ldr_pkg::MIN_DIM) ? ldr_pkg::MIN_DIM :
                (reg_w > MAXW) ? MAXW : reg_w;
            h = (reg_h < ldr_pkg::MIN_DIM) ? ldr_pkg::MIN_DIM :
                (reg_h > ldr_pkg::MAX_HEIGHT) ? ldr_pkg::MAX_HEIGHT : reg_h;
            if (col < w && row < h)
            begin
                for (int r = 0; r < 5; r++)
                    for (int c = 0; c < 4; c++)
                        win[r][c] = win[r][c+1];
                for (int r = 0; r < 4; r++)
                begin
                    slot = (row + r) & 3;
                    win[r][4] = line_mem[slot*MAXW + col];
                end
                win[4][4] = px;
                line_mem[(row & 3)*MAXW + col] = px;
                if (col >= 4 && row >= 4)
                begin
                    s = 0;
                    foreach (win[r, c])
                        s += win[r][c].in_blue + win[r][c].in_green + win[r][c].in_red;
                    ctr = win[2][2];
                    e.out_blue    = tone(ctr.in_blue, s);
                    e.out_green   = tone(ctr.in_green, s);
                    e.out_red     = tone(ctr.in_red, s);
                    e.out_opacity = ctr.in_opacity;
                    e.frame_end   = (row == h - 1 && col == w - 1);
                    expected_q.push_back(e);
                end
            end
            if (col + 1 >= w)
            begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col = col + 1;
            end
        endfunction

        function string check_word(ldr_pkg::out_word_t got);
            ldr_pkg::out_word_t e;
            string              msg;
            if (expected_q.size() == 0)
                return $sformatf("output word %h with nothing expected", got);
            e = expected_q.pop_front();
            msg = "";
            if (got.out_blue != e.out_blue)
                msg = {msg, $sformatf(" blue %0d/%0d", got.out_blue, e.out_blue)};
            if (got.out_green != e.out_green)
                msg = {msg, $sformatf(" green %0d/%0d", got.out_green, e.out_green)};
            if (got.out_red != e.out_red)
                msg = {msg, $sformatf(" red %0d/%0d", got.out_red, e.out_red)};
            if (got.out_opacity != e.out_opacity)
                msg = {msg, $sformatf(" opacity %0d/%0d", got.out_opacity, e.out_opacity)};
            if (got.frame_end != e.frame_end)
                msg = {msg, $sformatf(" frame_end %0d/%0d", got.frame_end, e.frame_end)};
            return msg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [1:0]                     cfg_index = ldr_pkg::REG_WIDTH;
    logic [ldr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    ldr_pkg::in_word_t              in_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    ldr_pkg::out_word_t             out_word;

    tone_scoreboard sb = new();
    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;      // long stretch with neither side idling
    bit  hold_req = 1'b0;     // asks the receiver for one long hold-off
    int  rand_items = 0;

    ldr_window_tone_filter_core #(.MAX_WIDTH(MAXW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task report(string msg);
        $display("MISMATCH @%0t:%s", $time, msg);
        fail_count++;
    endtask

    // Receiver: samples before the edge's updates land, then picks next stall.
    initial
    begin
        string msg;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                msg = sb.check_word(out_word);
                if (msg != "") report(msg);
            end
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= (!no_idle && $urandom_range(99) < 14);
        end
    end

    // Watchdog: cycles with no word moving on either side.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= DOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task write_reg(logic [1:0] idx, logic [ldr_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_write <= 1'b0;
    endtask

    // Block idle: input off, all words out, then let border pixels drain.
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task send_pixel(ldr_pkg::in_word_t px);
        if (!no_idle && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(px);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic ldr_pkg::in_word_t rand_pixel();
        ldr_pkg::in_word_t p;
        p.in_blue    = rand_byte();
        p.in_green   = rand_byte();
        p.in_red     = rand_byte();
        p.in_opacity = rand_byte();
        return p;
    endfunction

    task setup(int w, int h, int g);
        wait_idle();
        in_valid <= 1'b0;
        write_reg(ldr_pkg::REG_WIDTH, ldr_pkg::CFG_DATA_W'(w));
        write_reg(ldr_pkg::REG_HEIGHT, ldr_pkg::CFG_DATA_W'(h));
        write_reg(ldr_pkg::REG_GAIN, ldr_pkg::CFG_DATA_W'(g & 9'h1FF));
    endtask

    // Whole frame of random pixels under the current registers.
    task random_frame();
        do
        begin
            send_pixel(rand_pixel());
            rand_items++;
            no_idle = (rand_items > 300 && rand_items < 480);
        end
        while (sb.col != 0 || sb.row != 0);
    endtask

    initial
    begin
        ldr_pkg::in_word_t px;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: saturated frame at full positive gain, clamps high
        setup(5, 5, 255);
        px = '{8'd255, 8'd255, 8'd255, 8'd255};
        repeat (25) send_pixel(px);
        // most negative gain on extreme bytes, clamps low
        setup(5, 5, -256);
        for (int i = 0; i < 25; i++)
        begin
            px.in_blue    = (i % 2) ? 8'd255 : 8'd0;
            px.in_green   = (i % 3) ? 8'd255 : 8'd0;
            px.in_red     = (i % 4) ? 8'd0 : 8'd255;
            px.in_opacity = (i % 5) ? 8'd0 : 8'd255;
            send_pixel(px);
        end

        // Width and height under range act as the minimum
        setup(0, 0, $urandom_range(510) - 255);
        random_frame();

        // Registers changed mid-frame: stop inside row 7 of an 8x10 frame,
        // then shrink both so column and row are past the new limits.
        setup(8, 10, $urandom_range(510) - 255);
        repeat (63) send_pixel(rand_pixel());
        // sender pause until every expected word is out
        wait_idle();
        write_reg(ldr_pkg::REG_WIDTH, ldr_pkg::CFG_DATA_W'(6));
        write_reg(ldr_pkg::REG_HEIGHT, ldr_pkg::CFG_DATA_W'(5));
        random_frame();

        // Random frames, mostly small
        while (rand_items < 820)
        begin
            setup($urandom_range(12, 5), $urandom_range(10, 5), $urandom_range(511) - 256);
            if (rand_items > 500 && rand_items < 650 && !hold_req)
                hold_req = 1'b1;   // receiver holds off, input fills up behind it
            random_frame();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/ldr_pkg.sv
sv/ldr_front.sv
sv/ldr_queue.sv
sv/ldr_back.sv
sv/ldr_window_tone_filter_core.sv
sv/ldr_core_checker.sv
dv/tb_ldr_window_tone_filter_core.sv
